// ===== design/pcid_pkg.sv =====
package pcid_pkg;

    // Default frame limit in bytes, begin and end characters included
    localparam int MAX_FRAME_DEF = 256;

    // Frames shorter than this carry no ID
    localparam int MIN_FRAME = 11;

    // Begin-ID characters and the six-bit mode offset
    localparam logic [6:0] BEGIN_SIX   = 7'h08;
    localparam logic [6:0] BEGIN_SEVEN = 7'h28;
    localparam logic [7:0] SIX_OFFSET  = 8'h20;

    // Field delimiters
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_ASTERISK  = 8'h2A;

    // Result tdata layout
    localparam int TD_W        = 128;
    localparam int TD_BODY_W   = 118;
    localparam int TD_FLEN_LSB = 118;
    localparam int FLEN_W      = 9;

    typedef enum logic [1:0] {
        ST_PARSED   = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_SHORT    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_NONE         = 3'd0,
        PH_SERIAL       = 3'd1,
        PH_CLASS        = 3'd2,
        PH_COMPAT_FIRST = 3'd3,
        PH_COMPAT       = 3'd4,
        PH_DESC         = 3'd5,
        PH_DONE         = 3'd6
    } phase_t;

    typedef struct packed {
        logic [6:0] rx_char;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] revision;
        logic [55:0] eisa_id;
        logic        serial_present;
        logic [7:0]  class_start;
        logic [7:0]  class_length;
        logic [7:0]  compat_start;
        logic [7:0]  compat_length;
        logic [7:0]  desc_start;
        logic [7:0]  desc_length;
        logic        checksum_ok;
        logic [8:0]  frame_length;
    } result_t;

    // Handshake control from the parse core to the two register stages
    typedef struct packed {
        logic fire;
        logic load;
    } core_ctl_t;

endpackage

// ===== design/pcid_in_reg.sv =====
module pcid_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  pcid_pkg::in_item_t  item_in,
    input  pcid_pkg::core_ctl_t ctl,
    output logic                item_valid,
    output pcid_pkg::in_item_t  item
);

    logic               valid_reg;
    logic               valid_next;
    pcid_pkg::in_item_t item_reg;

    // Take a new request when empty or when the held one is consumed
    assign s_axis_tready = !valid_reg || ctl.fire;

    always_comb begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            valid_next = 1'b1;
        end else if (ctl.fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the core consumes it
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/pcid_frame_core.sv =====
module pcid_frame_core #(
    parameter int MAX_FRAME = pcid_pkg::MAX_FRAME_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  pcid_pkg::in_item_t   item,
    input  logic                 out_space,
    output pcid_pkg::core_ctl_t  ctl,
    output pcid_pkg::result_t    res
);

    localparam int POS_W = $clog2(MAX_FRAME + 1);

    typedef struct packed {
        logic            serial;
        logic [2:0]      found;
        logic [2:0][7:0] starts;
        logic [2:0][7:0] lens;
    } fields_t;

    // Close the open field at position fe (exclusive)
    function automatic fields_t close_field(
        input fields_t          f,
        input pcid_pkg::phase_t ph,
        input logic [POS_W-1:0] fb,
        input logic [POS_W-1:0] fe
    );
        fields_t        r;
        logic [POS_W:0] e_w;
        logic [POS_W:0] b_w;
        logic [1:0]     slot;
        logic           store;
        r     = f;
        e_w   = {1'b0, fe};
        b_w   = {1'b0, fb};
        slot  = 2'd0;
        store = 1'b0;
        case (ph)
            pcid_pkg::PH_SERIAL: begin
                r.serial = (e_w == b_w + (POS_W+1)'(8));
            end
            pcid_pkg::PH_CLASS: begin
                slot  = 2'd0;
                store = 1'b1;
            end
            pcid_pkg::PH_COMPAT_FIRST, pcid_pkg::PH_COMPAT: begin
                slot  = 2'd1;
                store = 1'b1;
            end
            pcid_pkg::PH_DESC: begin
                slot  = 2'd2;
                store = 1'b1;
            end
            default: begin
                store = 1'b0;
            end
        endcase
        if (store && (e_w > b_w + (POS_W+1)'(1))) begin
            r.found[slot]  = 1'b1;
            r.starts[slot] = 8'(fb);
            r.lens[slot]   = 8'(e_w - b_w);
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'd0, n};
        end else begin
            c = 8'h37 + {4'd0, n};
        end
        return c;
    endfunction

    logic             in_frame_reg, in_frame_next;
    logic             six_reg, six_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [6:0]       last0_reg, last0_next;
    logic [6:0]       last1_reg, last1_next;
    logic [11:0]      rev_reg, rev_next;
    logic [55:0]      id_reg, id_next;
    pcid_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0] begin_reg, begin_next;
    fields_t          fld_reg, fld_next;

    logic             res_valid;
    logic             do_clear;
    logic             do_start;
    logic [6:0]       raw;
    logic [7:0]       off;
    logic [7:0]       a;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] len;
    logic [6:0]       end_raw;
    logic [7:0]       csum;
    logic             any_field;
    fields_t          fin;

    // Parse one character against the frame state
    always_comb begin
        in_frame_next = in_frame_reg;
        six_next      = six_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        last0_next    = last0_reg;
        last1_next    = last1_reg;
        rev_next      = rev_reg;
        id_next       = id_reg;
        phase_next    = phase_reg;
        begin_next    = begin_reg;
        fld_next      = fld_reg;
        res           = '0;
        res_valid     = 1'b0;
        do_clear      = 1'b0;
        do_start      = 1'b0;
        fin           = fld_reg;
        csum          = '0;
        any_field     = 1'b0;

        raw     = item.rx_char;
        off     = six_reg ? pcid_pkg::SIX_OFFSET : 8'h00;
        a       = {1'b0, raw} + off;
        p       = pos_reg;
        len     = p + POS_W'(1);
        end_raw = six_reg ? (pcid_pkg::BEGIN_SIX + 7'd1) : (pcid_pkg::BEGIN_SEVEN + 7'd1);

        if (item.restart) begin
            do_clear = 1'b1;
        end else if (!in_frame_reg) begin
            // Hunt for a begin-ID character
            if (raw == pcid_pkg::BEGIN_SIX || raw == pcid_pkg::BEGIN_SEVEN) begin
                do_clear = 1'b1;
                do_start = 1'b1;
            end
        end else if (raw == end_raw) begin
            // End of frame: report and go back to hunting
            res_valid        = 1'b1;
            do_clear         = 1'b1;
            res.frame_length = 9'(len);
            if (len < POS_W'(pcid_pkg::MIN_FRAME)) begin
                res.status = pcid_pkg::ST_SHORT;
            end else begin
                if (phase_reg != pcid_pkg::PH_NONE && phase_reg != pcid_pkg::PH_DONE) begin
                    fin = close_field(fld_reg, phase_reg, begin_reg, len - POS_W'(3));
                end
                csum = sum_reg + {1'b0, raw} - {1'b0, last0_reg} - {1'b0, last1_reg};
                any_field = fin.serial || (fin.found != 3'b000);
                res.status         = pcid_pkg::ST_PARSED;
                res.revision       = rev_reg;
                res.eisa_id        = id_reg;
                res.serial_present = fin.serial;
                res.class_start    = fin.starts[0];
                res.class_length   = fin.lens[0];
                res.compat_start   = fin.starts[1];
                res.compat_length  = fin.lens[1];
                res.desc_start     = fin.starts[2];
                res.desc_length    = fin.lens[2];
                res.checksum_ok    = !any_field ||
                    ((({1'b0, last1_reg} + off) == hex_char(csum[7:4])) &&
                     (({1'b0, last0_reg} + off) == hex_char(csum[3:0])));
            end
        end else begin
            // Revision and EISA ID from the fixed positions
            if (p == POS_W'(1) || p == POS_W'(2)) begin
                rev_next = {rev_reg[5:0], raw[5:0]};
            end else if (p >= POS_W'(3) && p <= POS_W'(9)) begin
                id_next = {id_reg[47:0], a};
            end else if (p == POS_W'(10)) begin
                if (a == pcid_pkg::CH_BACKSLASH) begin
                    phase_next = pcid_pkg::PH_SERIAL;
                    begin_next = POS_W'(11);
                end else begin
                    phase_next = pcid_pkg::PH_DONE;
                end
            end else begin
                // Step through the optional delimited fields
                case (phase_reg)
                    pcid_pkg::PH_SERIAL, pcid_pkg::PH_CLASS, pcid_pkg::PH_COMPAT: begin
                        if (a == pcid_pkg::CH_BACKSLASH) begin
                            fld_next   = close_field(fld_reg, phase_reg, begin_reg, p);
                            begin_next = len;
                            case (phase_reg)
                                pcid_pkg::PH_SERIAL: phase_next = pcid_pkg::PH_CLASS;
                                pcid_pkg::PH_CLASS:  phase_next = pcid_pkg::PH_COMPAT_FIRST;
                                default:             phase_next = pcid_pkg::PH_DESC;
                            endcase
                        end
                    end
                    pcid_pkg::PH_COMPAT_FIRST: begin
                        if (a == pcid_pkg::CH_BACKSLASH) begin
                            fld_next   = close_field(fld_reg, phase_reg, begin_reg, p);
                            phase_next = pcid_pkg::PH_DESC;
                            begin_next = len;
                        end else begin
                            if (a == pcid_pkg::CH_ASTERISK) begin
                                begin_next = len;
                            end
                            phase_next = pcid_pkg::PH_COMPAT;
                        end
                    end
                    pcid_pkg::PH_DESC: begin
                        if (a == pcid_pkg::CH_SEMICOLON) begin
                            fld_next   = close_field(fld_reg, phase_reg, begin_reg, p);
                            phase_next = pcid_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            sum_next   = sum_reg + {1'b0, raw};
            last1_next = last0_reg;
            last0_next = raw;
            pos_next   = len;

            // Abandon a frame that fills the limit without an end character
            if (len >= POS_W'(MAX_FRAME)) begin
                res_valid        = 1'b1;
                do_clear         = 1'b1;
                res.status       = pcid_pkg::ST_OVERFLOW;
                res.frame_length = 9'(MAX_FRAME);
            end
        end

        if (do_clear) begin
            in_frame_next = 1'b0;
            six_next      = 1'b0;
            pos_next      = '0;
            sum_next      = '0;
            last0_next    = '0;
            last1_next    = '0;
            rev_next      = '0;
            id_next       = '0;
            phase_next    = pcid_pkg::PH_NONE;
            begin_next    = '0;
            fld_next      = '0;
        end
        if (do_start) begin
            in_frame_next = 1'b1;
            six_next      = (raw == pcid_pkg::BEGIN_SIX);
            sum_next      = {1'b0, raw};
            pos_next      = POS_W'(1);
        end
    end

    // Advance unless a result is due and the result register is still full
    assign ctl.fire = item_valid && (!res_valid || out_space);
    assign ctl.load = ctl.fire && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            six_reg      <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            last0_reg    <= '0;
            last1_reg    <= '0;
            rev_reg      <= '0;
            id_reg       <= '0;
            phase_reg    <= pcid_pkg::PH_NONE;
            begin_reg    <= '0;
            fld_reg      <= '0;
        end else if (ctl.fire) begin
            in_frame_reg <= in_frame_next;
            six_reg      <= six_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            last0_reg    <= last0_next;
            last1_reg    <= last1_next;
            rev_reg      <= rev_next;
            id_reg       <= id_next;
            phase_reg    <= phase_next;
            begin_reg    <= begin_next;
            fld_reg      <= fld_next;
        end
    end

endmodule

// ===== design/pcid_out_reg.sv =====
module pcid_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcid_pkg::core_ctl_t ctl,
    input  pcid_pkg::result_t   res_in,
    input  logic                m_axis_tready,
    output logic                m_axis_tvalid,
    output pcid_pkg::result_t   res,
    output logic                out_space
);

    logic              valid_reg;
    logic              valid_next;
    pcid_pkg::result_t res_reg;

    assign out_space = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            res_reg <= res_in;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign res           = res_reg;

endmodule

// ===== design/pnp_com_id_parser.sv =====
// Serial plug-and-play COM device ID parser.
// The slave channel takes one received character per request (tdata[6:0]);
// tuser set drops any partial frame and returns the parser to hunting for a
// begin-ID character. The master channel gives one result request per frame:
// tuser holds the status (parsed, overflowed, too short) and tdata the
// revision, EISA ID, serial flag, field starts and lengths, checksum match
// and frame length. Characters that end no frame give no result.
// A result passes through the input register, which takes the request
// holding the end character, and then the result register, which the parse
// logic loads when that register has room. Throughput is one character per
// cycle unless a result waits on a full result register; the parse state
// updates once per character in a single pass.
// Reset empties both registers and puts the parser into hunting; no clearing
// pass follows. When the receiver stalls, the held result stays stable;
// characters that give no result keep flowing, and a character that would
// give a result waits in the input register, which drops s_axis_tready.
module pnp_com_id_parser #(
    parameter int MAX_FRAME = pcid_pkg::MAX_FRAME_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [6:0] rx_char, [7] zero fill
    input  logic         s_axis_tuser,   // [0] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [11:0] revision, [67:12] eisa_id, [68] serial_present,
    // [76:69] class_start, [84:77] class_length, [92:85] compat_start,
    // [100:93] compat_length, [108:101] desc_start, [116:109] desc_length,
    // [117] checksum_ok, [126:118] frame_length, [127] zero fill
    output logic [127:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // [1:0] status
);

    pcid_pkg::in_item_t  item_in;
    pcid_pkg::in_item_t  item;
    logic                item_valid;
    pcid_pkg::core_ctl_t ctl;
    pcid_pkg::result_t   res_core;
    pcid_pkg::result_t   res_out;
    logic                out_space;

    assign item_in.rx_char = s_axis_tdata[6:0];
    assign item_in.restart = s_axis_tuser;

    pcid_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .item_in       (item_in),
        .ctl           (ctl),
        .item_valid    (item_valid),
        .item          (item)
    );

    pcid_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (out_space),
        .ctl        (ctl),
        .res        (res_core)
    );

    pcid_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .res_in        (res_core),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .res           (res_out),
        .out_space     (out_space)
    );

    // Pack the result fields, first field in the lowest bits
    assign m_axis_tdata = {1'b0, res_out.frame_length, res_out.checksum_ok,
                           res_out.desc_length, res_out.desc_start,
                           res_out.compat_length, res_out.compat_start,
                           res_out.class_length, res_out.class_start,
                           res_out.serial_present, res_out.eisa_id,
                           res_out.revision};
    assign m_axis_tuser = res_out.status;

endmodule

// ===== design/pcid_checker.sv =====
module pcid_checker #(
    parameter int MAX_FRAME = pcid_pkg::MAX_FRAME_DEF
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    localparam int FLEN_MSB = pcid_pkg::TD_FLEN_LSB + pcid_pkg::FLEN_W - 1;

    logic [8:0]   flen;
    logic [117:0] body;

    assign flen = m_axis_tdata[FLEN_MSB:pcid_pkg::TD_FLEN_LSB];
    assign body = m_axis_tdata[pcid_pkg::TD_BODY_W-1:0];

    // A stalled result holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled result");

    // A short frame carries only its length
    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == pcid_pkg::ST_SHORT |->
            flen < 9'(pcid_pkg::MIN_FRAME) && body == '0)
        else $error("short frame result malformed");

    // An abandoned frame reports the limit and nothing else
    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == pcid_pkg::ST_OVERFLOW |->
            flen == 9'(MAX_FRAME) && body == '0)
        else $error("overflow result malformed");

endmodule

bind pnp_com_id_parser pcid_checker #(
    .MAX_FRAME (MAX_FRAME)
) u_pcid_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/pnp_id_check_pkg.sv =====
package pnp_id_check_pkg;

    import pcid_pkg::*;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_HEX_A    = 8'h41;
    localparam int         FRAME_LIMIT = MAX_FRAME_DEF;

    // Uppercase hex character of one nibble
    function automatic logic [7:0] hex_digit(logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return CH_HEX_A + 8'(n) - 8'd10;
    endfunction

    class pnp_id_scoreboard;
        // parser state, advanced on every accepted input request
        bit        in_frame;
        bit        six_mode;
        int        pos;
        bit [7:0]  sum;
        bit [6:0]  prev0;
        bit [6:0]  prev1;
        bit [11:0] rev;
        bit [55:0] id;
        phase_t    phase;
        int        fbegin;
        bit        serial;
        bit [7:0]  starts[3];
        bit [7:0]  lens[3];

        result_t   expected_q[$];
        int        mismatches;
        int        results_seen;
        int        chars_noted;
        int        n_parsed;
        int        n_overflow;
        int        n_short;
        int        n_with_fields;
        int        n_bad_sum;

        function new();
            clear();
        endfunction

        function void clear();
            in_frame = 1'b0;
            six_mode = 1'b0;
            pos      = 0;
            sum      = '0;
            prev0    = '0;
            prev1    = '0;
            rev      = '0;
            id       = '0;
            phase    = PH_NONE;
            fbegin   = 0;
            serial   = 1'b0;
            foreach (starts[i]) begin
                starts[i] = '0;
                lens[i]   = '0;
            end
        endfunction

        // Keep a field only when it holds two characters or more
        function void store_field(int slot, int stop);
            if (stop > fbegin + 1) begin
                starts[slot] = 8'(fbegin);
                lens[slot]   = 8'(stop - fbegin);
            end
        endfunction

        // Close the open field; stop is the first position past it
        function void close_field(int stop);
            case (phase)
                PH_SERIAL:                serial = (stop - fbegin == 8);
                PH_CLASS:                 store_field(0, stop);
                PH_COMPAT_FIRST, PH_COMPAT: store_field(1, stop);
                PH_DESC:                  store_field(2, stop);
                default: ;
            endcase
        endfunction

        // Advance the ID and field tracking by one interpreted character
        function void scan_char(int p, logic [7:0] a);
            if (p >= 3 && p <= 9) begin
                id = {id[47:0], a};
            end else if (p == 10) begin
                if (a == CH_BACKSLASH) begin
                    phase  = PH_SERIAL;
                    fbegin = p + 1;
                end else begin
                    phase = PH_DONE;
                end
            end else if (p > 10) begin
                case (phase)
                    PH_SERIAL, PH_CLASS, PH_COMPAT: begin
                        if (a == CH_BACKSLASH) begin
                            close_field(p);
                            case (phase)
                                PH_SERIAL: phase = PH_CLASS;
                                PH_CLASS:  phase = PH_COMPAT_FIRST;
                                default:   phase = PH_DESC;
                            endcase
                            fbegin = p + 1;
                        end
                    end
                    PH_COMPAT_FIRST: begin
                        if (a == CH_BACKSLASH) begin
                            close_field(p);
                            phase  = PH_DESC;
                            fbegin = p + 1;
                        end else begin
                            // a leading asterisk is not part of the driver name
                            if (a == CH_ASTERISK) fbegin = p + 1;
                            phase = PH_COMPAT;
                        end
                    end
                    PH_DESC: begin
                        if (a == CH_SEMICOLON) begin
                            close_field(p);
                            phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        endfunction

        // Note one accepted input request; queue the result it causes, if any
        function void note_char(logic [6:0] raw, logic rst);
            logic [7:0] off;
            logic [7:0] a;
            logic [7:0] s;
            logic [6:0] end_raw;
            int         p;
            int         flen;
            result_t    r;
            bit         any_field;

            chars_noted++;
            if (rst) begin
                clear();
                return;
            end

            // hunt for a begin-ID character
            if (!in_frame) begin
                if (raw == BEGIN_SIX || raw == BEGIN_SEVEN) begin
                    clear();
                    in_frame = 1'b1;
                    six_mode = (raw == BEGIN_SIX);
                    sum      = 8'(raw);
                    pos      = 1;
                end
                return;
            end

            off     = six_mode ? SIX_OFFSET : 8'h00;
            a       = 8'(raw) + off;
            end_raw = (six_mode ? BEGIN_SIX : BEGIN_SEVEN) + 7'd1;
            p       = pos;
            r       = '0;

            // end-ID character: report the frame
            if (raw == end_raw) begin
                flen           = p + 1;
                r.frame_length = 9'(flen);
                if (flen < MIN_FRAME) begin
                    r.status = ST_SHORT;
                    n_short++;
                end else begin
                    // an open field ends where the checksum starts
                    if (phase >= PH_SERIAL && phase <= PH_DESC) close_field(flen - 3);
                    s = sum + 8'(raw) - 8'(prev0) - 8'(prev1);
                    any_field = serial || lens[0] != 0 || lens[1] != 0 || lens[2] != 0;
                    r.status         = ST_PARSED;
                    r.revision       = rev;
                    r.eisa_id        = id;
                    r.serial_present = serial;
                    r.class_start    = starts[0];
                    r.class_length   = lens[0];
                    r.compat_start   = starts[1];
                    r.compat_length  = lens[1];
                    r.desc_start     = starts[2];
                    r.desc_length    = lens[2];
                    r.checksum_ok    = !any_field ||
                                       ((8'(prev1) + off) == hex_digit(s[7:4]) &&
                                        (8'(prev0) + off) == hex_digit(s[3:0]));
                    n_parsed++;
                    if (any_field) n_with_fields++;
                    if (!r.checksum_ok) n_bad_sum++;
                end
                expected_q.push_back(r);
                clear();
                return;
            end

            // revision comes from the raw bytes at positions one and two
            if (p == 1 || p == 2) rev = {rev[5:0], raw[5:0]};
            scan_char(p, a);
            sum   = sum + 8'(raw);
            prev1 = prev0;
            prev0 = raw;
            pos   = p + 1;

            // abandon a frame that fills the buffer
            if (pos >= FRAME_LIMIT) begin
                r.status       = ST_OVERFLOW;
                r.frame_length = 9'(FRAME_LIMIT);
                n_overflow++;
                expected_q.push_back(r);
                clear();
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %h, got %h", results_seen, name, want, seen);
            end
        endfunction

        // Check one accepted result request against the oldest expectation
        function void check(result_t got);
            result_t want;

            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected (status %0d, length %0d)",
                             results_seen, got.status, got.frame_length);
                return;
            end
            want = expected_q.pop_front();
            compare_field("status",         want.status,         got.status);
            compare_field("revision",       want.revision,       got.revision);
            compare_field("eisa_id",        want.eisa_id,        got.eisa_id);
            compare_field("serial_present", want.serial_present, got.serial_present);
            compare_field("class_start",    want.class_start,    got.class_start);
            compare_field("class_length",   want.class_length,   got.class_length);
            compare_field("compat_start",   want.compat_start,   got.compat_start);
            compare_field("compat_length",  want.compat_length,  got.compat_length);
            compare_field("desc_start",     want.desc_start,     got.desc_start);
            compare_field("desc_length",    want.desc_length,    got.desc_length);
            compare_field("checksum_ok",    want.checksum_ok,    got.checksum_ok);
            compare_field("frame_length",   want.frame_length,   got.frame_length);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ===== bench/tb_top.sv =====
module tb_top;

    import pcid_pkg::*;
    import pnp_id_check_pkg::*;

    localparam int ITEMS     = 1250;
    localparam int LONG_HOLD = 400;
    // interpreted value of the end-ID character, the same in both modes
    localparam logic [7:0] END_TEXT = 8'(BEGIN_SEVEN) + 8'd1;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    pnp_id_scoreboard board;
    in_item_t         script[$];
    logic [7:0]       frame_text[$];
    int               send_idle_pct;
    int               stall_pct;
    int               hold_req;
    int               hold_left;
    int               items_fed;

    pnp_com_id_parser u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Drive the result-side ready: long hold when asked, else random stalls
    always begin
        @(negedge aclk);
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left     = hold_left - 1;
        end else if (hold_req > 0) begin
            m_axis_tready = 1'b0;
            hold_left     = hold_req - 1;
            hold_req      = 0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic result_t unpack_result(logic [127:0] d, logic [1:0] u);
        result_t r;
        r.status         = status_t'(u);
        r.revision       = d[11:0];
        r.eisa_id        = d[67:12];
        r.serial_present = d[68];
        r.class_start    = d[76:69];
        r.class_length   = d[84:77];
        r.compat_start   = d[92:85];
        r.compat_length  = d[100:93];
        r.desc_start     = d[108:101];
        r.desc_length    = d[116:109];
        r.checksum_ok    = d[117];
        r.frame_length   = d[TD_FLEN_LSB +: FLEN_W];
        return r;
    endfunction

    // Check every accepted result request
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check(unpack_result(m_axis_tdata, m_axis_tuser));
    end

    function automatic void queue_char(logic [6:0] r, logic rst);
        in_item_t item;
        item.rx_char = r;
        item.restart = rst;
        script.push_back(item);
    endfunction

    function automatic logic [6:0] any_raw_but(logic [6:0] no1, logic [6:0] no2);
        logic [6:0] r;
        do begin
            r = 7'($urandom_range(127));
        end while (r == no1 || r == no2);
        return r;
    endfunction

    // Printable character that never ends the frame; delimiters only when wild
    function automatic logic [7:0] text_char(bit wild);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(8'h7e, 8'h20));
        end while (c == END_TEXT || (!wild && (c == CH_BACKSLASH ||
                   c == CH_SEMICOLON || c == CH_ASTERISK)));
        return c;
    endfunction

    function automatic void add_text(int n);
        repeat (n) frame_text.push_back(text_char($urandom_range(9) == 0));
    endfunction

    // Offer one request, idling first at the current rate
    task automatic send_char(input in_item_t item);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, item.rx_char};
        s_axis_tuser  = item.restart;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        board.note_char(item.rx_char, item.restart);
    endtask

    task automatic play_script(input bit counted);
        if (counted) items_fed += script.size();
        foreach (script[i]) send_char(script[i]);
        script.delete();
    endtask

    // Drop valid and hold until every expected result is back
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // Well-formed ID frame with random fields and a mostly correct checksum
    task automatic build_id_frame(input bit six);
        logic [7:0] off;
        logic [7:0] csum;
        logic [7:0] lo;
        logic [6:0] begin_raw;
        logic [6:0] end_raw;
        int         shape;

        off       = six ? SIX_OFFSET : 8'h00;
        begin_raw = six ? BEGIN_SIX : BEGIN_SEVEN;
        end_raw   = begin_raw + 7'd1;
        frame_text.delete();

        // revision bytes are raw, EISA ID is text
        repeat (2) frame_text.push_back(8'(any_raw_but(end_raw, end_raw)) + off);
        repeat (7) frame_text.push_back(text_char(1'b0));

        shape = $urandom_range(5);
        if (shape == 5) begin
            frame_text.push_back(text_char(1'b1));
        end else if (shape > 0) begin
            frame_text.push_back(CH_BACKSLASH);
            add_text($urandom_range(1) ? 8 : $urandom_range(10));
            if (shape >= 2) begin
                frame_text.push_back(CH_BACKSLASH);
                add_text($urandom_range(10));
            end
            if (shape >= 3) begin
                frame_text.push_back(CH_BACKSLASH);
                if ($urandom_range(1)) frame_text.push_back(CH_ASTERISK);
                add_text($urandom_range(10));
            end
            if (shape >= 4) begin
                frame_text.push_back(CH_BACKSLASH);
                add_text($urandom_range(16));
                if ($urandom_range(3) != 0) frame_text.push_back(CH_SEMICOLON);
            end
        end

        // checksum over every raw byte of the frame except the two hex digits
        if ($urandom_range(9) != 0) begin
            csum = 8'(begin_raw) + 8'(end_raw);
            foreach (frame_text[i]) csum += frame_text[i] - off;
            lo = hex_digit(csum[3:0]);
            if ($urandom_range(7) == 0) lo = hex_digit(csum[3:0] + 4'd1);
            frame_text.push_back(hex_digit(csum[7:4]));
            frame_text.push_back(lo);
        end

        queue_char(begin_raw, 1'b0);
        foreach (frame_text[i]) queue_char(7'(frame_text[i] - off), 1'b0);
        queue_char(end_raw, 1'b0);
        frame_text.delete();
    endtask

    // Frame that never ends and fills the buffer
    task automatic build_overflow(input bit six);
        logic [6:0] begin_raw;
        begin_raw = six ? BEGIN_SIX : BEGIN_SEVEN;
        queue_char(begin_raw, 1'b0);
        repeat (FRAME_LIMIT - 1) queue_char(any_raw_but(begin_raw + 7'd1, begin_raw + 7'd1), 1'b0);
    endtask

    // Pick one random sequence and play it
    task automatic play_random_frame();
        int         kind;
        int         n;
        logic [6:0] begin_raw;

        kind = $urandom_range(99);
        if (kind < 70) begin
            build_id_frame($urandom_range(1));
            play_script(1'b1);
        end else if (kind < 82) begin
            // short frame, ten bytes at most
            begin_raw = $urandom_range(1) ? BEGIN_SIX : BEGIN_SEVEN;
            queue_char(begin_raw, 1'b0);
            repeat ($urandom_range(8))
                queue_char(any_raw_but(begin_raw + 7'd1, begin_raw + 7'd1), 1'b0);
            queue_char(begin_raw + 7'd1, 1'b0);
            play_script(1'b1);
        end else if (kind < 92) begin
            // cut a frame short with a restart
            build_id_frame($urandom_range(1));
            n = $urandom_range(script.size() - 2, 1);
            while (script.size() > n) void'(script.pop_back());
            queue_char(7'($urandom_range(127)), 1'b1);
            play_script(1'b1);
        end else begin
            // line noise while hunting
            repeat ($urandom_range(4, 1))
                queue_char(any_raw_but(BEGIN_SIX, BEGIN_SEVEN), $urandom_range(4) == 0);
            play_script(1'b0);
        end
    endtask

    initial begin
        #2_000_000;
        $display("timeout: results still outstanding or input stuck");
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int target;

        board = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // hunting: ignored characters at both extremes, restart while idle
        queue_char(7'h00, 1'b0);
        queue_char(7'h7f, 1'b0);
        queue_char(7'h55, 1'b1);
        // shortest six-bit frame, begin then end
        queue_char(BEGIN_SIX, 1'b0);
        queue_char(BEGIN_SIX + 7'd1, 1'b0);
        // seven-bit frame dropped by a restart
        queue_char(BEGIN_SEVEN, 1'b0);
        queue_char(7'h7f, 1'b0);
        queue_char(7'h00, 1'b1);
        // shortest parsed frame: revision bytes at the extremes, ID, no options
        queue_char(BEGIN_SEVEN, 1'b0);
        queue_char(7'h7f, 1'b0);
        queue_char(7'h00, 1'b0);
        for (int i = 0; i < 7; i++) queue_char(7'(CH_HEX_A) + 7'(i), 1'b0);
        queue_char(BEGIN_SEVEN + 7'd1, 1'b0);
        play_script(1'b1);
        wait_drained();

        // random frames under four idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_req      = LONG_HOLD;
                end
                1: begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default: begin
                    send_idle_pct = 24;
                    stall_pct     = 24;
                end
            endcase
            if (ph == 1 || ph == 2) begin
                build_overflow(ph == 1);
                play_script(1'b1);
            end
            target = ITEMS * (ph + 1) / 4;
            while (items_fed < target) play_random_frame();
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        $display("%0d requests, %0d results: %0d parsed (%0d with fields, %0d bad checksums),",
                 board.chars_noted, board.results_seen, board.n_parsed,
                 board.n_with_fields, board.n_bad_sum);
        $display("%0d overflowed, %0d short; %0d field mismatches",
                 board.n_overflow, board.n_short, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
